/* hw/rtl/sha512_hash_engine_assert.svh */
// Assertion macros for the hash engine checker.
`ifndef SHA512_HASH_ENGINE_ASSERT_SVH
`define SHA512_HASH_ENGINE_ASSERT_SVH
`define SHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/sha_pkg.sv */
// Package: types, constants and functions of the SHA-512 engine.
`default_nettype none
package sha_pkg;
  localparam int LenBits = 64;
  localparam logic [63:0] LoMask =
    (LenBits >= 64) ? '1 : ((64'd1 << (LenBits % 64)) - 64'd1);
  localparam logic [63:0] HiMask =
    (LenBits >= 128) ? '1 : (LenBits <= 64) ? '0 : ((64'd1 << (LenBits % 64)) - 64'd1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_INIT, CMD_PUT, CMD_START, CMD_ROUND, CMD_ADD, CMD_RESET
  } sha_op_t;

  typedef struct packed {
    sha_op_t     op;
    logic [6:0]  pos;
    logic [7:0]  bval;
    logic [6:0]  rnd;
  } sha_cmd_t;

  typedef struct packed {
    logic [6:0]  pos;
    logic [63:0] lo;
    logic [63:0] hi;
  } sha_stat_t;

  function automatic logic [63:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 64'h6a09e667f3bcc908;
      3'd1: init_h = 64'hbb67ae8584caa73b;
      3'd2: init_h = 64'h3c6ef372fe94f82b;
      3'd3: init_h = 64'ha54ff53a5f1d36f1;
      3'd4: init_h = 64'h510e527fade682d1;
      3'd5: init_h = 64'h9b05688c2b3e6c1f;
      3'd6: init_h = 64'h1f83d9abfb41bd6b;
      default: init_h = 64'h5be0cd19137e2179;
    endcase
  endfunction

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
endpackage
`default_nettype wire

/* hw/rtl/sha_datapath.sv */
// Datapath: byte packing, schedule window, round logic, hash state, length counter.
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sha_cmd_t   cmd,
  input  wire logic [2:0] rd_idx,
  output logic [63:0]     rd_word,
  output sha_stat_t       stat
);
  logic [63:0] hv [8];
  logic [63:0] wv [8];
  logic [63:0] win [16];
  logic [63:0] byte_count;

  logic [3:0]  widx;
  logic [5:0]  sh;
  logic [63:0] w15, w2, s0, s1, wt, t1, t2, wnew, e, a;

  always_comb begin
    widx = cmd.pos[6:3];
    sh = {3'd7 - cmd.pos[2:0], 3'd0};
    w15 = win[4'(cmd.rnd - 7'd15)];
    w2 = win[4'(cmd.rnd - 7'd2)];
    s0 = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
    s1 = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
    wnew = win[cmd.rnd[3:0]] + s0 + win[4'(cmd.rnd - 7'd7)] + s1;
    wt = (cmd.rnd < 7'd16) ? win[cmd.rnd[3:0]] : wnew;
    e = wv[4];
    a = wv[0];
    t1 = wv[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
       + ((e & wv[5]) ^ (~e & wv[6])) + wt + RoundK[cmd.rnd];
    t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
       + ((a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]));
    rd_word = hv[rd_idx];
    stat.pos = byte_count[6:0];
    stat.lo = (byte_count << 3) & LoMask;
    stat.hi = {61'd0, byte_count[63:61]} & HiMask;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == CMD_RESET) begin
      for (int i = 0; i < 8; i++) begin
        hv[i] <= init_h(3'(i));
      end
      byte_count <= '0;
    end else begin
      case (cmd.op)
        CMD_INIT: byte_count <= byte_count + 64'd1;
        CMD_START: begin
          for (int i = 0; i < 8; i++) begin
            wv[i] <= hv[i];
          end
        end
        CMD_ROUND: begin
          if (cmd.rnd >= 7'd16) begin
            win[cmd.rnd[3:0]] <= wnew;
          end
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
          wv[0] <= t1 + t2;
        end
        CMD_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hv[i] <= hv[i] + wv[i];
          end
        end
        default: ;
      endcase
    end
    if (cmd.op == CMD_PUT || cmd.op == CMD_INIT) begin
      if (cmd.pos[2:0] == 3'd0) begin
        win[widx] <= {56'd0, cmd.bval} << sh;
      end else begin
        win[widx] <= win[widx] | ({56'd0, cmd.bval} << sh);
      end
    end
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= '0;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/sha_ctrl.sv */
// Controller: intake, padding sequence, round sequencing and digest output.
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire sha_in_t     in_item,
  output logic             in_stall,
  output logic             out_valid,
  output logic [2:0]       out_idx,
  input  wire logic        out_stall,
  output sha_cmd_t         cmd,
  output logic [2:0]       rd_idx,
  input  wire sha_stat_t   stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_ADD, S_PAD, S_OUT, S_CLR
  } state_t;

  state_t      state;
  logic [6:0]  rnd;
  logic [6:0]  ppos;
  logic        finishing;
  logic        pend_last;
  logic        wrap_pad;
  logic        tail_pad;
  logic [7:0]  pbyte;
  logic        acc;

  assign in_stall = (state != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign rd_idx = out_idx;

  // wrap_pad: block without the length field; tail_pad: block after it, no 0x80
  always_comb begin
    if (!tail_pad && ppos == stat.pos) begin
      pbyte = 8'h80;
    end else if (!wrap_pad && ppos >= 7'd120) begin
      pbyte = 8'(stat.lo >> {3'd7 - ppos[2:0], 3'd0});
    end else if (!wrap_pad && ppos >= 7'd112) begin
      pbyte = 8'(stat.hi >> {3'd7 - ppos[2:0], 3'd0});
    end else begin
      pbyte = 8'h00;
    end
    cmd = '{op: CMD_NONE, pos: ppos, bval: pbyte, rnd: rnd};
    case (state)
      S_IDLE: begin
        cmd.pos = stat.pos;
        cmd.bval = in_item.data_byte;
        if (acc && in_item.has_data) begin
          cmd.op = CMD_INIT;
        end
      end
      S_PAD: cmd.op = CMD_PUT;
      S_START: cmd.op = CMD_START;
      S_ROUND: cmd.op = CMD_ROUND;
      S_ADD: cmd.op = CMD_ADD;
      S_CLR: cmd.op = CMD_RESET;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd <= '0;
      ppos <= '0;
      finishing <= 1'b0;
      pend_last <= 1'b0;
      wrap_pad <= 1'b0;
      tail_pad <= 1'b0;
      out_valid <= 1'b0;
      out_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (in_item.has_data && stat.pos == 7'd127) begin
              pend_last <= in_item.last_byte;
              state <= S_START;
            end else if (in_item.last_byte) begin
              state <= S_PAD;
              finishing <= 1'b1;
              ppos <= in_item.has_data ? stat.pos + 7'd1 : stat.pos;
              wrap_pad <= in_item.has_data ? (stat.pos >= 7'd111) : (stat.pos >= 7'd112);
            end
          end
        end
        S_PAD: begin
          ppos <= ppos + 7'd1;
          if (ppos == 7'd127) begin
            state <= S_START;
          end
        end
        S_START: begin
          rnd <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd == 7'd79) begin
            rnd <= '0;
            state <= S_ADD;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ADD: begin
          if (finishing) begin
            if (wrap_pad) begin
              wrap_pad <= 1'b0;
              tail_pad <= 1'b1;
              state <= S_PAD;
            end else begin
              state <= S_OUT;
              out_valid <= 1'b1;
              out_idx <= '0;
            end
          end else if (pend_last) begin
            finishing <= 1'b1;
            pend_last <= 1'b0;
            ppos <= 7'd0;
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              out_valid <= 1'b0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          finishing <= 1'b0;
          tail_pad <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/sha512_hash_engine.sv */
// Top level of the SHA-512 hash engine.
// Input channel: one message byte per transaction (has_data), last_byte
// ends the message; a transaction with last_byte and no data is allowed.
// Output channel: eight digest words H0..H7 per message, word_index 0..7,
// last_word on the eighth.
// Bytes are taken one per cycle while a block fills. The 128th byte of a
// block stalls the input for compression (load, 80 rounds, hash update).
// A last transaction stalls the input while the padding bytes go in at one
// per cycle up to the end of the block, followed by its compression.
// A tail of 112 bytes or more adds a second block of padding, which is
// compressed in turn. A last byte that fills a block gets its own
// compression, then one padding block with its compression.
// Then come eight output transactions, one per cycle when not stalled, and
// a clear step to restore the initial hash before the next input is taken.
// A stalled output holds its word; the input stays stalled meanwhile.
// Reset (rst, synchronous) loads the initial hash and clears the length.
`default_nettype none
module sha512_hash_engine
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sha_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sha_out_t      out_data
);
  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [2:0]  rd_idx;
  logic [2:0]  out_idx;
  logic [63:0] rd_word;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_item(in_data), .in_stall, .out_valid, .out_idx,
    .out_stall, .cmd, .rd_idx, .stat
  );

  sha_datapath u_dp (.clk, .rst, .cmd, .rd_idx, .rd_word, .stat);

  assign out_data = '{digest_word: rd_word, word_index: out_idx,
                      last_word: (out_idx == 3'd7)};
endmodule
`default_nettype wire

/* hw/rtl/sha_checker.sv */
// Port checker for the hash engine, bound to the top level.
`default_nettype none
`include "sha512_hash_engine_assert.svh"
module sha_checker
  import sha_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire sha_out_t out_data
);
  `SHA_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `SHA_ASSERT_IMPL(a_busy, clk, rst, out_valid, in_stall)
  `SHA_ASSERT_IMPL(a_lastw, clk, rst, out_valid, out_data.last_word == (out_data.word_index == 3'd7))
  `SHA_ASSERT_NEXT(a_seq, clk, rst, out_valid && !out_stall && !out_data.last_word, out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
endmodule
bind sha512_hash_engine sha_checker u_chk (.clk, .rst, .in_stall, .out_valid,
  .out_stall, .out_data);
`default_nettype wire

/* test/tb_sha512_hash_engine.sv */
// Testbench for the SHA-512 hash engine: byte stream in, digest words checked.
`default_nettype none
module tb_sha512_hash_engine;
  import sha_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sha_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sha_out_t out_data;

  localparam int WatchdogLimit = 20000;

  always #1 clk = ~clk;

  sha512_hash_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [63:0] hv [8];
  logic [63:0] blk [16];
  logic [63:0] nbytes;
  sha_out_t    digest_q [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          timed_out = 0;

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void hash_init();
    hv[0] = 64'h6a09e667f3bcc908; hv[1] = 64'hbb67ae8584caa73b;
    hv[2] = 64'h3c6ef372fe94f82b; hv[3] = 64'ha54ff53a5f1d36f1;
    hv[4] = 64'h510e527fade682d1; hv[5] = 64'h9b05688c2b3e6c1f;
    hv[6] = 64'h1f83d9abfb41bd6b; hv[7] = 64'h5be0cd19137e2179;
    nbytes = '0;
  endfunction

  function automatic void compress();
    logic [63:0] v [8];
    logic [63:0] w [80];
    logic [63:0] t1, t2;
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) w[r] = blk[r];
      else w[r] = w[r-16] + (ror(w[r-15], 1) ^ ror(w[r-15], 8) ^ (w[r-15] >> 7))
                  + w[r-7] + (ror(w[r-2], 19) ^ ror(w[r-2], 61) ^ (w[r-2] >> 6));
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + w[r] + RoundK[r];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endfunction

  function automatic void place_byte(input int pos, input logic [7:0] b);
    int sh;
    sh = (7 - (pos & 7)) * 8;
    if ((pos & 7) == 0) blk[pos >> 3] = 64'(b) << sh;
    else blk[pos >> 3] |= 64'(b) << sh;
    if (pos == 127) compress();
  endfunction

  function automatic void predict_digest(input sha_in_t t);
    int pos;
    logic [63:0] lo, hi;
    sha_out_t o;
    if (t.has_data) begin
      place_byte(int'(nbytes[6:0]), t.data_byte);
      nbytes++;
    end
    if (!t.last_byte) return;
    pos = int'(nbytes[6:0]);
    lo = nbytes << 3;
    hi = nbytes >> 61;
    if (LenBits < 64) begin
      lo &= (64'd1 << LenBits) - 64'd1;
      hi = '0;
    end else if (LenBits < 128) begin
      hi &= (64'd1 << (LenBits - 64)) - 64'd1;
    end
    place_byte(pos, 8'h80);
    pos++;
    if (pos > 112) begin
      while (pos < 128) begin place_byte(pos, 8'h00); pos++; end
      pos = 0;
    end
    while (pos < 112) begin place_byte(pos, 8'h00); pos++; end
    for (int i = 0; i < 8; i++) place_byte(112 + i, hi[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) place_byte(120 + i, lo[63 - 8*i -: 8]);
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hv[k];
      o.word_index = 3'(k);
      o.last_word = (k == 7);
      digest_q.push_back(o);
    end
    hash_init();
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_item(input logic [7:0] b, input bit hd, input bit lst);
    sha_in_t t;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    t.data_byte = b; t.has_data = hd; t.last_byte = lst;
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk iff !in_stall);
    predict_digest(t);
  endtask

  task automatic send_message(input int len, input int mode);
    logic [7:0] b;
    bit tail_data;
    tail_data = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'($urandom);
        1: b = 8'hff;
        default: b = 8'h00;
      endcase
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(b, 1'b1, (i == len - 1) && tail_data);
    end
    if (!tail_data) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (digest_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_pad_boundaries();
    int lens [6] = '{1, 111, 112, 127, 128, 0};
    foreach (lens[i]) send_message(lens[i], i % 3);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b1);
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 60) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 3);
        default: len = $urandom_range(4, 30);
      endcase
      send_message(len, 0);
      sent += len + 1;
    end
  endtask

  // receive side stalls
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sha_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_data);
      end else begin
        e = digest_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                     e.digest_word, e.word_index, e.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("tb_sha512_hash_engine failed");
      $finish;
    end
  end

  initial begin
    hash_init();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_pad_boundaries();
    test_random_messages();
    in_valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("tb_sha512_hash_engine passed");
    end else begin
      $display("tb_sha512_hash_engine failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
